// File: src/plps_pkg.sv
// Shared types and constants for the patterned line pixel stepper.
package plps_pkg;

  localparam int DASH_W      = 16;
  localparam int COLOR_W     = 4;
  localparam int ADDR_W      = 24;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 2;

  localparam logic [DASH_W-1:0]  DASH_RESET  = 16'hFFFF;
  localparam logic [COLOR_W-1:0] COLOR_RESET = 4'hF;
  localparam int SCREEN_WIDTH_RESET  = 800;
  localparam int SCREEN_HEIGHT_RESET = 600;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DASH_PATTERN  = 2'd0,
    REG_DRAW_COLOR    = 2'd1,
    REG_SCREEN_WIDTH  = 2'd2,
    REG_SCREEN_HEIGHT = 2'd3
  } cfg_reg_t;

  // Input item action codes.
  typedef enum logic {
    ACT_START = 1'b0,
    ACT_STEP  = 1'b1
  } action_t;

endpackage

// File: src/plps_in_if.sv
// Input channel carrying line start and step commands.
interface plps_in_if #(
  parameter int COORD_BITS = 13
) ();
  logic                         valid;
  logic                         ready;
  plps_pkg::action_t            action;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;

  modport source (output valid, action, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, action, start_x, start_y, end_x, end_y, output ready);
endinterface

// File: src/plps_out_if.sv
// Output channel carrying one visited point and its framebuffer write.
interface plps_out_if #(
  parameter int COORD_BITS = 13
) ();
  logic                               valid;
  logic                               ready;
  logic signed [COORD_BITS-1:0]       point_x;
  logic signed [COORD_BITS-1:0]       point_y;
  logic [plps_pkg::ADDR_W-1:0]        pixel_address;
  logic [plps_pkg::COLOR_W-1:0]       pixel_color;
  logic                               write_enable;
  logic                               last_point;
  logic                               idle;

  modport source (output valid, point_x, point_y, pixel_address, pixel_color,
                  write_enable, last_point, idle, input ready);
  modport sink   (input valid, point_x, point_y, pixel_address, pixel_color,
                  write_enable, last_point, idle, output ready);
endinterface

// File: src/patterned_line_pixel_stepper_core.sv
// Top level of the patterned Bresenham line stepper with clipping and addressing.
// Path: an accepted beat enters the input register, then moves to the result
//   register once the result register is empty or its beat is being taken.
// Throughput: one beat per cycle while pixel_out.ready does not stall the output.
// Reset: synchronous, active high; clears walk state, valid flags and restores
//   configuration defaults (solid pattern, color 15, 800 by 600 screen).
module patterned_line_pixel_stepper_core #(
  parameter int COORD_BITS     = 13,
  parameter int PATTERN_LENGTH = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  plps_in_if.sink                            line_in,
  plps_out_if.source                         pixel_out,
  input  logic                               cfg_we,
  input  logic [plps_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [plps_pkg::CFG_DATA_W-1:0]    cfg_data
);

  // The error term needs two bits beyond a coordinate, and its update math
  // needs two more so that the doubled value and the sums never overflow.
  localparam int ERR_W  = COORD_BITS + 2;
  localparam int WORK_W = ERR_W + 2;
  localparam int IDX_W  = $clog2(PATTERN_LENGTH);
  localparam int MUL_W  = (2 * COORD_BITS > plps_pkg::ADDR_W) ?
                          2 * COORD_BITS : plps_pkg::ADDR_W;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(PATTERN_LENGTH - 1);

  // ---------------------------------------------------------------------------
  // Configuration registers; the user must write them only while the engine is quiet (not enforced here).
  // ---------------------------------------------------------------------------
  logic [plps_pkg::DASH_W-1:0]  dash_pattern;
  logic [plps_pkg::COLOR_W-1:0] draw_color;
  logic [COORD_BITS-1:0]        screen_width;
  logic [COORD_BITS-1:0]        screen_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      dash_pattern  <= plps_pkg::DASH_RESET;
      draw_color    <= plps_pkg::COLOR_RESET;
      screen_width  <= COORD_BITS'(plps_pkg::SCREEN_WIDTH_RESET);
      screen_height <= COORD_BITS'(plps_pkg::SCREEN_HEIGHT_RESET);
    end else if (cfg_we) begin
      unique case (plps_pkg::cfg_reg_t'(cfg_index))
        plps_pkg::REG_DASH_PATTERN:  dash_pattern  <= cfg_data[plps_pkg::DASH_W-1:0];
        plps_pkg::REG_DRAW_COLOR:    draw_color    <= cfg_data[plps_pkg::COLOR_W-1:0];
        plps_pkg::REG_SCREEN_WIDTH:  screen_width  <= cfg_data[COORD_BITS-1:0];
        plps_pkg::REG_SCREEN_HEIGHT: screen_height <= cfg_data[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input register. On capture the endpoint deltas, directions and the initial
  // error term are worked out so the walk stage only has to take one step.
  // ---------------------------------------------------------------------------
  logic                         inq_valid;
  plps_pkg::action_t            inq_action;
  logic signed [COORD_BITS-1:0] inq_x1, inq_y1, inq_x2, inq_y2;
  logic [COORD_BITS-1:0]        inq_span_x, inq_span_y;
  logic                         inq_x_down, inq_y_down;
  logic signed [ERR_W-1:0]      inq_err;

  logic                         in_beat;
  logic                         advance;
  logic                         res_valid;

  logic signed [COORD_BITS:0]   diff_x, diff_y;
  logic [COORD_BITS-1:0]        abs_x, abs_y;
  logic signed [ERR_W-1:0]      err_start;

  // The item in the input register moves on whenever the result register is
  // empty or its beat is being taken, so a new beat can enter every cycle unless the output stalls.
  assign advance      = inq_valid && (!res_valid || pixel_out.ready);
  assign line_in.ready = !inq_valid || advance;
  assign in_beat      = line_in.valid && line_in.ready;

  always_comb begin
    diff_x = (COORD_BITS+1)'(line_in.end_x) - (COORD_BITS+1)'(line_in.start_x);
    diff_y = (COORD_BITS+1)'(line_in.end_y) - (COORD_BITS+1)'(line_in.start_y);
    abs_x  = diff_x[COORD_BITS] ? COORD_BITS'(-diff_x) : COORD_BITS'(diff_x);
    abs_y  = diff_y[COORD_BITS] ? COORD_BITS'(-diff_y) : COORD_BITS'(diff_y);
    err_start = signed'(ERR_W'(abs_x)) - signed'(ERR_W'(abs_y));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inq_valid <= 1'b0;
    end else if (in_beat) begin
      inq_valid <= 1'b1;
    end else if (advance) begin
      inq_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      inq_action <= line_in.action;
      inq_x1     <= line_in.start_x;
      inq_y1     <= line_in.start_y;
      inq_x2     <= line_in.end_x;
      inq_y2     <= line_in.end_y;
      inq_span_x <= abs_x;
      inq_span_y <= abs_y;
      // Equal coordinates count as going down, as in the classic walk.
      inq_x_down <= !(line_in.start_x < line_in.end_x);
      inq_y_down <= !(line_in.start_y < line_in.end_y);
      inq_err    <= err_start;
    end
  end

  // ---------------------------------------------------------------------------
  // Walk state.
  // ---------------------------------------------------------------------------
  logic signed [COORD_BITS-1:0] walk_x, walk_y, goal_x, goal_y;
  logic [COORD_BITS-1:0]        span_x, span_y;
  logic                         x_goes_down, y_goes_down;
  logic signed [ERR_W-1:0]      error_term;
  logic [IDX_W-1:0]             pattern_index;
  logic                         line_busy;

  logic signed [COORD_BITS-1:0] walk_x_next, walk_y_next;
  logic signed [ERR_W-1:0]      error_term_next;
  logic [IDX_W-1:0]             pattern_index_next;
  logic                         line_busy_next;

  // A start beat replaces the line in progress; the point it names is visited
  // in the same pass, so every field below is the start value or the state.
  logic                         is_start, do_visit, at_goal, pattern_on, on_screen, we;
  logic signed [COORD_BITS-1:0] cur_wx, cur_wy, cur_gx, cur_gy;
  logic [COORD_BITS-1:0]        cur_sx, cur_sy;
  logic                         cur_xd, cur_yd;
  logic signed [ERR_W-1:0]      cur_err;
  logic [IDX_W-1:0]             cur_idx;
  logic signed [WORK_W-1:0]     err_w, e2_w, dx_w, dy_w, err_sum;
  logic                         step_x, step_y;
  logic [MUL_W-1:0]             addr_wide;

  always_comb begin
    is_start = (inq_action == plps_pkg::ACT_START);
    cur_wx   = is_start ? inq_x1     : walk_x;
    cur_wy   = is_start ? inq_y1     : walk_y;
    cur_gx   = is_start ? inq_x2     : goal_x;
    cur_gy   = is_start ? inq_y2     : goal_y;
    cur_sx   = is_start ? inq_span_x : span_x;
    cur_sy   = is_start ? inq_span_y : span_y;
    cur_xd   = is_start ? inq_x_down : x_goes_down;
    cur_yd   = is_start ? inq_y_down : y_goes_down;
    cur_err  = is_start ? inq_err    : error_term;
    cur_idx  = is_start ? '0         : pattern_index;
    do_visit = is_start || line_busy;
    at_goal  = (cur_wx == cur_gx) && (cur_wy == cur_gy);

    // Bresenham decision: compare twice the error against both deltas.
    err_w  = WORK_W'(cur_err);
    e2_w   = err_w <<< 1;
    dx_w   = signed'(WORK_W'(cur_sx));
    dy_w   = signed'(WORK_W'(cur_sy));
    step_x = e2_w > -dy_w;
    step_y = e2_w < dx_w;
    err_sum = err_w - (step_x ? dy_w : '0) + (step_y ? dx_w : '0);

    // Pattern positions past the dash register width are always off.
    pattern_on = (32'(cur_idx) < plps_pkg::DASH_W) &&
                 dash_pattern[4'(cur_idx)];
    on_screen  = !cur_wx[COORD_BITS-1] && !cur_wy[COORD_BITS-1] &&
                 ($unsigned(cur_wx) < screen_width) &&
                 ($unsigned(cur_wy) < screen_height);
    we         = pattern_on && on_screen;

    // Both coordinates are known non-negative whenever the address is used.
    addr_wide = MUL_W'($unsigned(cur_wy)) * MUL_W'(screen_width) +
                MUL_W'($unsigned(cur_wx));

    walk_x_next        = cur_wx;
    walk_y_next        = cur_wy;
    error_term_next    = cur_err;
    pattern_index_next = cur_idx;
    line_busy_next     = 1'b0;
    if (!at_goal) begin
      if (step_x) begin
        walk_x_next = cur_xd ? cur_wx - 1'b1 : cur_wx + 1'b1;
      end
      if (step_y) begin
        walk_y_next = cur_yd ? cur_wy - 1'b1 : cur_wy + 1'b1;
      end
      error_term_next    = ERR_W'(err_sum);
      pattern_index_next = (cur_idx == IDX_LAST) ? '0 : cur_idx + 1'b1;
      line_busy_next     = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walk_x        <= '0;
      walk_y        <= '0;
      goal_x        <= '0;
      goal_y        <= '0;
      span_x        <= '0;
      span_y        <= '0;
      x_goes_down   <= 1'b0;
      y_goes_down   <= 1'b0;
      error_term    <= '0;
      pattern_index <= '0;
      line_busy     <= 1'b0;
    end else if (advance && do_visit) begin
      walk_x        <= walk_x_next;
      walk_y        <= walk_y_next;
      goal_x        <= cur_gx;
      goal_y        <= cur_gy;
      span_x        <= cur_sx;
      span_y        <= cur_sy;
      x_goes_down   <= cur_xd;
      y_goes_down   <= cur_yd;
      error_term    <= error_term_next;
      pattern_index <= pattern_index_next;
      line_busy     <= line_busy_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register. A step with no line in progress yields an idle beat with
  // every other field zero; a point that is not drawn has zero address and
  // color.
  // ---------------------------------------------------------------------------
  logic signed [COORD_BITS-1:0]  res_point_x, res_point_y;
  logic [plps_pkg::ADDR_W-1:0]   res_address;
  logic [plps_pkg::COLOR_W-1:0]  res_color;
  logic                          res_write, res_last, res_idle;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (pixel_out.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_point_x <= do_visit ? cur_wx : '0;
      res_point_y <= do_visit ? cur_wy : '0;
      res_address <= (do_visit && we) ? addr_wide[plps_pkg::ADDR_W-1:0] : '0;
      res_color   <= (do_visit && we) ? draw_color : '0;
      res_write   <= do_visit && we;
      res_last    <= do_visit && at_goal;
      res_idle    <= !do_visit;
    end
  end

  assign pixel_out.valid         = res_valid;
  assign pixel_out.point_x       = res_point_x;
  assign pixel_out.point_y       = res_point_y;
  assign pixel_out.pixel_address = res_address;
  assign pixel_out.pixel_color   = res_color;
  assign pixel_out.write_enable  = res_write;
  assign pixel_out.last_point    = res_last;
  assign pixel_out.idle          = res_idle;

`ifndef NO_ASSERTIONS
  // A line only ends with the beat that reaches its endpoint.
  a_busy_ends_on_last: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $fell(line_busy)) |-> ($past(advance) && res_valid && res_last))
    else $error("line ended without a last point result");

  // A held input item is never dropped while the output side stalls.
  a_input_held: assert property (@(posedge clk) disable iff (rst)
    (inq_valid && !advance) |=> inq_valid)
    else $error("pending input item lost");

  // An idle result never carries a pixel write or an endpoint mark.
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_idle) |-> (!res_write && !res_last))
    else $error("idle result carries a write or last point");
`endif

endmodule
